// ----- design/ostb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ostb_pkg: shared types and constants of the one-shot timer bank
// Action codes, command and response words, and the control and status
// bundles between the bank and its timer cells.
// ----------------------------------------------------------------------------
package ostb_pkg;

  localparam int TIMER_COUNT_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int MASK_WIDTH      = 8;
  localparam int INDEX_WIDTH     = 8;
  localparam int THRESH_WIDTH    = 32;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_START  = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_QUERY  = 3'd4
  } action_t;

  typedef struct packed {
    logic [2:0]              action;
    logic [INDEX_WIDTH-1:0]  timer_index;
    logic [THRESH_WIDTH-1:0] threshold;
    logic                    has_callback;
  } cmd_word_t;

  typedef struct packed {
    logic                  ok;
    logic                  is_timed_out;
    logic                  enable_flag;
    logic [MASK_WIDTH-1:0] expired_mask;
    logic [MASK_WIDTH-1:0] notify_mask;
  } rsp_word_t;

  typedef struct packed {
    logic tick;
    logic create;
    logic start;
    logic stop;
    logic sel;
  } cell_ctrl_t;

  typedef struct packed {
    logic expire;
    logic notify;
    logic enabled;
    logic timed_out;
  } cell_stat_t;

endpackage : ostb_pkg
`default_nettype wire

// ----- design/ostb_timer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ostb_timer: one timer cell
// Holds counter, threshold and flags of one timer; reports the flags it takes
// on for the current word and whether it expires on a tick.
// ----------------------------------------------------------------------------
module ostb_timer
  import ostb_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    take,
  input  wire cell_ctrl_t              ctrl,
  input  wire logic [THRESH_WIDTH-1:0] threshold,
  input  wire logic                    has_callback,
  output cell_stat_t                   stat
);

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] thresh;
  logic [COUNT_WIDTH-1:0] thresh_next;
  logic                   enabled;
  logic                   enabled_next;
  logic                   timed_out;
  logic                   timed_out_next;
  logic                   callback;
  logic                   callback_next;
  logic                   reached;

  assign reached = count >= thresh;

  always_comb begin
    count_next     = count;
    thresh_next    = thresh;
    enabled_next   = enabled;
    timed_out_next = timed_out;
    callback_next  = callback;
    if (ctrl.tick) begin
      if (enabled) begin
        if (reached) begin
          timed_out_next = 1'b1;
          enabled_next   = 1'b0;
        end else begin
          count_next = count + COUNT_WIDTH'(1);
        end
      end
    end else if (ctrl.sel) begin
      if (ctrl.create) begin
        enabled_next   = 1'b0;
        thresh_next    = COUNT_WIDTH'(threshold);
        count_next     = '0;
        timed_out_next = 1'b0;
        callback_next  = has_callback;
      end else if (ctrl.start) begin
        enabled_next = 1'b1;
      end else if (ctrl.stop) begin
        enabled_next = 1'b0;
      end
    end
  end

  assign stat.expire    = ctrl.tick && enabled && reached;
  assign stat.notify    = ctrl.tick && enabled && reached && callback;
  assign stat.enabled   = enabled_next;
  assign stat.timed_out = timed_out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      thresh    <= '0;
      enabled   <= 1'b0;
      timed_out <= 1'b0;
      callback  <= 1'b0;
    end else if (take) begin
      count     <= count_next;
      thresh    <= thresh_next;
      enabled   <= enabled_next;
      timed_out <= timed_out_next;
      callback  <= callback_next;
    end
  end

endmodule : ostb_timer
`default_nettype wire

// ----- design/ostb_rsp_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ostb_rsp_reg: response register
// Holds one response word until it is taken; loads a new word on each
// accepted command.
// ----------------------------------------------------------------------------
module ostb_rsp_reg
  import ostb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire rsp_word_t rsp_next,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_word_t      rsp,
  output logic           busy
);

  assign busy = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
  end

endmodule : ostb_rsp_reg
`default_nettype wire

// ----- design/one_shot_timer_bank.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// one_shot_timer_bank: bank of one-shot timers
// Takes one command word (tick, create, start, stop, query) per cycle, unless
// the response register stalls, and returns one response word for each, in order.
// ----------------------------------------------------------------------------
// The response of each accepted command word is loaded into the response
// register at the edge that takes the word; a new word is accepted every cycle
// as long as the response register is not stalled. All TIMER_COUNT timers
// compare and increment side by side in their own cells on a tick, so the
// rate does not depend on the number of timers. Only timers 0 to 7 appear in
// the expired and notify masks; higher timers run but are not reported.
module one_shot_timer_bank
  import ostb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire cmd_word_t cmd,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_word_t      rsp
);

  logic                   take;
  logic                   busy;
  logic                   is_tick;
  logic                   is_cmd;
  logic                   idx_ok;
  cell_ctrl_t             ctrl_base;
  cell_stat_t             stat     [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] expire_vec;
  logic [TIMER_COUNT-1:0] notify_vec;
  logic [TIMER_COUNT-1:0] enabled_vec;
  logic [TIMER_COUNT-1:0] timed_out_vec;
  logic [MASK_WIDTH-1:0]  expired_mask;
  logic [MASK_WIDTH-1:0]  notify_mask;
  rsp_word_t              rsp_next;

  assign cmd_stall = busy;
  assign take      = cmd_valid && !busy;

  assign is_tick = cmd.action == ACT_TICK;
  assign is_cmd  = cmd.action == ACT_CREATE || cmd.action == ACT_START ||
                   cmd.action == ACT_STOP   || cmd.action == ACT_QUERY;
  assign idx_ok  = {1'b0, cmd.timer_index} < (INDEX_WIDTH + 1)'(TIMER_COUNT);

  assign ctrl_base.tick   = is_tick;
  assign ctrl_base.create = cmd.action == ACT_CREATE;
  assign ctrl_base.start  = cmd.action == ACT_START;
  assign ctrl_base.stop   = cmd.action == ACT_STOP;
  assign ctrl_base.sel    = 1'b0;

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_timer
    cell_ctrl_t ctrl;

    always_comb begin
      ctrl     = ctrl_base;
      ctrl.sel = is_cmd && idx_ok && cmd.timer_index == INDEX_WIDTH'(i);
    end

    ostb_timer #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timer (
      .clk          (clk),
      .rst          (rst),
      .take         (take),
      .ctrl         (ctrl),
      .threshold    (cmd.threshold),
      .has_callback (cmd.has_callback),
      .stat         (stat[i])
    );

    assign expire_vec[i]    = stat[i].expire;
    assign notify_vec[i]    = stat[i].notify;
    assign enabled_vec[i]   = ctrl.sel && stat[i].enabled;
    assign timed_out_vec[i] = ctrl.sel && stat[i].timed_out;
  end

  for (genvar b = 0; b < MASK_WIDTH; b++) begin : g_mask
    if (b < TIMER_COUNT) begin : g_shown
      assign expired_mask[b] = expire_vec[b];
      assign notify_mask[b]  = notify_vec[b];
    end else begin : g_absent
      assign expired_mask[b] = 1'b0;
      assign notify_mask[b]  = 1'b0;
    end
  end

  assign rsp_next.ok           = is_tick || (is_cmd && idx_ok);
  assign rsp_next.is_timed_out = |timed_out_vec;
  assign rsp_next.enable_flag  = |enabled_vec;
  assign rsp_next.expired_mask = expired_mask;
  assign rsp_next.notify_mask  = notify_mask;

  ostb_rsp_reg u_rsp_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .rsp_next  (rsp_next),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .busy      (busy)
  );

`ifndef SYNTHESIS
  a_take_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    take |=> rsp_valid)
    else $error("accepted word left no response");

  a_notify_subset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.notify_mask & ~rsp.expired_mask) == '0)
    else $error("notify bit without expiry");

  a_flags_need_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> !rsp.enable_flag && !rsp.is_timed_out &&
                             rsp.expired_mask == '0)
    else $error("rejected word reports state");

  a_mask_only_tick: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.expired_mask != '0 |-> rsp.ok && !rsp.enable_flag &&
                                            !rsp.is_timed_out)
    else $error("expiry mask on a non-tick word");

  a_hold_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(rsp))
    else $error("response changed while stalled");
`endif

endmodule : one_shot_timer_bank
`default_nettype wire

// ----- verif/one_shot_timer_bank_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_bank_checker: response predictor and comparator
// Watches the command and response channels of the timer bank, keeps its own
// copy of every timer, predicts the response word of each accepted command
// and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module one_shot_timer_bank_checker
  import ostb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_stall,
  input  cmd_word_t cmd,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  rsp_word_t rsp,
  output int        pending,
  output int        fail_count
);

  typedef logic [COUNT_WIDTH_DEF-1:0] count_t;

  count_t    tick_cnt [TIMER_COUNT_DEF];
  count_t    limit    [TIMER_COUNT_DEF];
  logic      running  [TIMER_COUNT_DEF];
  logic      expired  [TIMER_COUNT_DEF];
  logic      callback [TIMER_COUNT_DEF];
  rsp_word_t expected_rsp_q[$];
  int        miss_count = 0;

  assign fail_count = miss_count;

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    miss_count++;
  endtask

  function automatic rsp_word_t step_timers(cmd_word_t w);
    rsp_word_t r;
    int        idx;
    r   = '0;
    idx = int'(w.timer_index);
    if (w.action == ACT_TICK) begin
      r.ok = 1'b1;
      for (int i = 0; i < TIMER_COUNT_DEF; i++) begin
        if (running[i]) begin
          if (tick_cnt[i] >= limit[i]) begin
            expired[i] = 1'b1;
            running[i] = 1'b0;
            if (i < MASK_WIDTH) begin
              r.expired_mask[i] = 1'b1;
              if (callback[i]) r.notify_mask[i] = 1'b1;
            end
          end else begin
            tick_cnt[i] = tick_cnt[i] + 1'b1;
          end
        end
      end
    end else if (w.action <= ACT_QUERY && idx < TIMER_COUNT_DEF) begin
      r.ok = 1'b1;
      case (w.action)
        ACT_CREATE: begin
          running[idx]  = 1'b0;
          limit[idx]    = count_t'(w.threshold);
          tick_cnt[idx] = '0;
          expired[idx]  = 1'b0;
          callback[idx] = w.has_callback;
        end
        ACT_START: running[idx] = 1'b1;
        ACT_STOP:  running[idx] = 1'b0;
        default: ;
      endcase
      r.is_timed_out = expired[idx];
      r.enable_flag  = running[idx];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      for (int i = 0; i < TIMER_COUNT_DEF; i++) begin
        tick_cnt[i] = '0;
        limit[i]    = '0;
        running[i]  = 1'b0;
        expired[i]  = 1'b0;
        callback[i] = 1'b0;
      end
      expected_rsp_q.delete();
    end else begin
      // compare before predicting: a response never belongs to this edge's word
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response word %h with none expected", rsp));
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.ok !== want.ok)
            report_mismatch($sformatf("ok got %b expected %b", rsp.ok, want.ok));
          if (rsp.is_timed_out !== want.is_timed_out)
            report_mismatch($sformatf("is_timed_out got %b expected %b",
                                      rsp.is_timed_out, want.is_timed_out));
          if (rsp.enable_flag !== want.enable_flag)
            report_mismatch($sformatf("enable_flag got %b expected %b",
                                      rsp.enable_flag, want.enable_flag));
          if (rsp.expired_mask !== want.expired_mask)
            report_mismatch($sformatf("expired_mask got %h expected %h",
                                      rsp.expired_mask, want.expired_mask));
          if (rsp.notify_mask !== want.notify_mask)
            report_mismatch($sformatf("notify_mask got %h expected %h",
                                      rsp.notify_mask, want.notify_mask));
        end
      end
      if (cmd_valid && !cmd_stall) expected_rsp_q.push_back(step_timers(cmd));
    end
    pending <= expected_rsp_q.size();
  end

endmodule : one_shot_timer_bank_checker

// ----- verif/one_shot_timer_bank_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_bank_tb: testbench of the one-shot timer bank
// Drives directed and random command words in bursts against a receiver
// that stalls on its own pattern, including a long hold-off and a full
// drain, while a checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module one_shot_timer_bank_tb;
  import ostb_pkg::*;

  localparam int         CLK_PERIOD   = 12;
  localparam int         IDLE_LIMIT   = 4000;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         RANDOM_WORDS = 1300;
  localparam int         HOLD_WORDS   = 80;
  localparam int         HOLD_CYCLES  = 150;
  localparam logic [2:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [2:0] ACT_RSVD_MID = 3'd6;
  localparam logic [2:0] ACT_RSVD_HI  = 3'd7;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_word_t cmd       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;
  logic      hold_req  = 1'b0;
  int        pending;
  int        fail_count;
  int        idle_cycles = 0;
  int        burst_left  = 0;

  one_shot_timer_bank dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  one_shot_timer_bank_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall pattern of its own, one long hold-off on request
  initial begin
    int mode;
    int len;
    bit held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 40);
      repeat (len) begin
        case (mode)
          0:       rsp_stall <= 1'b0;
          1:       rsp_stall <= 1'($urandom_range(0, 1));
          2:       rsp_stall <= ($urandom_range(0, 3) == 0);
          default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic cmd_word_t make_cmd(logic [2:0] act, int idx, logic [31:0] thr,
                                         logic cb);
    cmd_word_t w;
    w.action       = act;
    w.timer_index  = 8'(idx);
    w.threshold    = thr;
    w.has_callback = cb;
    return w;
  endfunction

  function automatic logic [31:0] random_threshold();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick < 4) return 32'($urandom);
    return 32'($urandom_range(0, 12));
  endfunction

  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int        pick;
    w    = make_cmd(ACT_TICK, $urandom_range(0, TIMER_COUNT_DEF - 1), random_threshold(),
                    1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w.action      = ACT_TICK;
      w.timer_index = 8'($urandom_range(0, 255));
      w.threshold   = 32'($urandom);
    end else if (pick < 50) begin
      w.action = ACT_CREATE;
    end else if (pick < 68) begin
      w.action = ACT_START;
    end else if (pick < 76) begin
      w.action = ACT_STOP;
    end else if (pick < 88) begin
      w.action = ACT_QUERY;
    end else if (pick < 95) begin
      w.action      = 3'($urandom_range(ACT_CREATE, ACT_QUERY));
      w.timer_index = 8'($urandom_range(TIMER_COUNT_DEF, 255));
      w.threshold   = 32'($urandom);
    end else begin
      w.action      = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
      w.timer_index = 8'($urandom_range(0, 255));
      w.threshold   = 32'($urandom);
    end
    return w;
  endfunction

  task automatic send_word(cmd_word_t w);
    cmd       <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(0, 20);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_paced(cmd_word_t w);
    send_word(w);
    pace();
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_paced(make_cmd(ACT_QUERY, 0, '0, 1'b0));
    send_paced(make_cmd(ACT_CREATE, 0, '0, 1'b1));
    send_paced(make_cmd(ACT_CREATE, 1, 32'd2, 1'b0));
    send_paced(make_cmd(ACT_CREATE, 7, '1, 1'b1));
    send_paced(make_cmd(ACT_START, 0, '0, 1'b0));
    send_paced(make_cmd(ACT_START, 1, '0, 1'b0));
    send_paced(make_cmd(ACT_START, 7, '0, 1'b0));
    repeat (4) send_paced(make_cmd(ACT_TICK, 0, '0, 1'b0));
    // restart after timeout: expires again on the next tick
    send_paced(make_cmd(ACT_START, 0, '0, 1'b0));
    send_paced(make_cmd(ACT_TICK, 255, '1, 1'b1));
    send_paced(make_cmd(ACT_STOP, 7, '0, 1'b0));
    send_paced(make_cmd(ACT_QUERY, 7, '0, 1'b0));
    send_paced(make_cmd(ACT_START, 7, '0, 1'b0));
    send_paced(make_cmd(ACT_CREATE, 7, 32'd1, 1'b0));
    send_paced(make_cmd(ACT_CREATE, TIMER_COUNT_DEF, 32'd3, 1'b1));
    send_paced(make_cmd(ACT_QUERY, 255, '0, 1'b0));
    send_paced(make_cmd(ACT_START, 128, '0, 1'b0));
    send_paced(make_cmd(ACT_RSVD_LO, 0, '1, 1'b1));
    send_paced(make_cmd(ACT_RSVD_HI, 255, '0, 1'b0));
    send_paced(make_cmd(ACT_RSVD_MID, 3, 32'h5a5a_a5a5, 1'b1));
    send_paced(make_cmd(ACT_TICK, 0, '0, 1'b0));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) wait_drained();
      if (n == 2 * RANDOM_WORDS / 3) begin
        // offer back to back while the receiver holds off
        hold_req <= 1'b1;
        repeat (HOLD_WORDS) send_word(random_word());
        hold_req <= 1'b0;
      end
      send_paced(random_word());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule : one_shot_timer_bank_tb
